[design/cvk_pkg.sv]
`default_nettype none
package cvk_pkg;

  // defaults for the top level parameters
  localparam int AXES_DEF = 8;
  localparam int FRAC_DEF = 16;

  localparam int DATA_W = 32;
  localparam int OPND_W = 34;
  localparam int PROD_W = 68;
  localparam int ACC_W  = 70;

  // register reset values
  localparam logic [31:0] TIME_STEP_RST  = 32'd2185;
  localparam logic [31:0] PROC_NOISE_RST = 32'd655;
  localparam logic [31:0] MEAS_NOISE_RST = 32'd655;

  // register indexes
  localparam logic [1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_PROC_NOISE = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  // item operations
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_SET_POS = 1'b1;

  // datapath micro steps, each one shared multiply and one consume
  localparam logic [4:0] ST_T2   = 5'd0;
  localparam logic [4:0] ST_T3   = 5'd1;
  localparam logic [4:0] ST_T4   = 5'd2;
  localparam logic [4:0] ST_QPP  = 5'd3;
  localparam logic [4:0] ST_QPV  = 5'd4;
  localparam logic [4:0] ST_QVV  = 5'd5;
  localparam logic [4:0] ST_PP1  = 5'd6;
  localparam logic [4:0] ST_PP2  = 5'd7;
  localparam logic [4:0] ST_PV   = 5'd8;
  localparam logic [4:0] ST_D1   = 5'd9;
  localparam logic [4:0] ST_D2   = 5'd10;
  localparam logic [4:0] ST_N00  = 5'd11;
  localparam logic [4:0] ST_N01A = 5'd12;
  localparam logic [4:0] ST_N01B = 5'd13;
  localparam logic [4:0] ST_N10A = 5'd14;
  localparam logic [4:0] ST_N10B = 5'd15;
  localparam logic [4:0] ST_N11  = 5'd16;
  localparam logic [4:0] ST_X1   = 5'd17;
  localparam logic [4:0] ST_X2   = 5'd18;
  localparam logic [4:0] ST_X3   = 5'd19;
  localparam logic [4:0] ST_X4   = 5'd20;
  localparam logic [4:0] ST_C1   = 5'd21;
  localparam logic [4:0] ST_C2   = 5'd22;
  localparam logic [4:0] ST_C3   = 5'd23;
  localparam logic [4:0] ST_C4   = 5'd24;
  localparam logic [4:0] ST_C5   = 5'd25;
  localparam logic [4:0] ST_C6   = 5'd26;

  // gain selects for the divider
  localparam logic [1:0] GAIN_00 = 2'd0;
  localparam logic [1:0] GAIN_01 = 2'd1;
  localparam logic [1:0] GAIN_10 = 2'd2;
  localparam logic [1:0] GAIN_11 = 2'd3;

  typedef struct packed {
    logic               op;
    logic [2:0]         axis;
    logic signed [31:0] value;
    logic               arrived;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         axis_out;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } out_word_t;

  typedef struct packed {
    logic       load_in;
    logic       load_state;
    logic       mul;
    logic       acc;
    logic       div_start;
    logic       wb;
    logic       fin;
    logic [1:0] div_sel;
    logic [4:0] step;
  } cvk_cmd_t;

  typedef struct packed {
    logic div_done;
    logic skip_math;
  } cvk_stat_t;

  // signed saturation to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed(ACC_W'(32'h7FFF_FFFF));
    lo = $signed({{(ACC_W-31){1'b1}}, 31'b0});
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return $signed(32'h8000_0000);
    end
    return x[31:0];
  endfunction

  // unsigned saturation to 32 bits of a non-negative value
  function automatic logic [31:0] usat32(input logic signed [ACC_W-1:0] x);
    if (|x[ACC_W-1:32]) begin
      return 32'hFFFF_FFFF;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sx(input logic signed [31:0] x);
    return ACC_W'(x);
  endfunction

  function automatic logic signed [ACC_W-1:0] ux(input logic [31:0] x);
    return $signed(ACC_W'(x));
  endfunction

endpackage
`default_nettype wire

[design/const_velocity_kalman_update.sv]
// Bank of per-axis constant-velocity Kalman filters, Q16.16 by default.
// Input channel (in_valid/in_ready/in_data): one word per item, either a
// measurement update or a set-position for one axis. Every input word gives
// exactly one result word on the output channel (out_valid/out_ready/out_data)
// holding the axis and its position and velocity estimate.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
// time step, process noise and measurement noise; it is always ready. The user
// must write it only while no item is in flight; the block does not check this.
// Sequence: a set-position word, or one for an axis beyond the bank, goes
// through the read, load, write-back and finish states, and finish waits
// while the output register is full. A measurement adds 27 products on one
// shared multiplier, each a multiply and a consume step, and four gain
// divisions on a radix-2 divider. One item is worked on at a time; the next
// word is accepted the cycle after the result enters the output register.
// The result sits in an output register; while the receiver stalls the
// next word is still accepted and computed, and waits for the register.
// Reset restores the register defaults and marks every axis as holding
// zero estimates, unit covariance and a zero last measurement.
`default_nettype none
module const_velocity_kalman_update #(
  parameter int AXES = cvk_pkg::AXES_DEF,
  parameter int FRAC_BITS = cvk_pkg::FRAC_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire cvk_pkg::in_word_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      cvk_pkg::out_word_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import cvk_pkg::*;

  cvk_cmd_t  cmd;
  cvk_stat_t stat;

  assign cfg_ready = 1'b1;

  cvk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cvk_datapath #(
    .AXES      (AXES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

[design/cvk_ram.sv]
`default_nettype none
module cvk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/cvk_div.sv]
`default_nettype none
module cvk_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output      logic               done,
  output      logic signed [31:0] quo
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [QW-1:0] dvd;
  logic [QW-1:0] quo_u;
  logic [31:0]   den_u;
  logic          neg;
  logic          zero;

  logic [32:0]   rem_sh;
  logic [33:0]   diff;
  logic          ge;
  logic          hi;
  logic [31:0]   num_abs;
  logic [31:0]   den_abs;

  assign num_abs = num[31] ? 32'(-num) : num;
  assign den_abs = den[31] ? 32'(-den) : den;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem, dvd[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_u};
  assign ge     = !diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= {num_abs, {FRAC_BITS{1'b0}}};
      den_u <= den_abs;
      neg   <= num[31] ^ den[31];
      zero  <= (den == '0);
      rem   <= '0;
      quo_u <= '0;
    end else if (busy) begin
      rem   <= ge ? diff[31:0] : rem_sh[31:0];
      dvd   <= {dvd[QW-2:0], 1'b0};
      quo_u <= {quo_u[QW-2:0], ge};
    end
  end

  // sign and saturate the magnitude; a zero divisor gives zero
  assign hi = |quo_u[QW-1:32];
  always_comb begin
    if (zero) begin
      quo = '0;
    end else if (!neg) begin
      quo = (hi || quo_u[31]) ? 32'sh7FFF_FFFF : $signed(quo_u[31:0]);
    end else begin
      quo = (hi || (quo_u[31] && |quo_u[30:0])) ? $signed(32'h8000_0000)
                                                : $signed(32'(-quo_u[31:0]));
    end
  end

endmodule
`default_nettype wire

[design/cvk_datapath.sv]
`default_nettype none
module cvk_datapath #(
  parameter int AXES = cvk_pkg::AXES_DEF,
  parameter int FRAC_BITS = cvk_pkg::FRAC_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cvk_pkg::in_word_t   in_data,
  output      cvk_pkg::out_word_t  out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire cvk_pkg::cvk_cmd_t   cmd,
  output      cvk_pkg::cvk_stat_t  stat
);
  import cvk_pkg::*;

  localparam int ADDR_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int RAM_W  = 6 * DATA_W;

  // configuration
  logic [31:0] t_reg;
  logic [31:0] q_reg;
  logic [31:0] r_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_reg <= TIME_STEP_RST;
      q_reg <= PROC_NOISE_RST;
      r_reg <= MEAS_NOISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:  t_reg <= cfg_data;
        REG_PROC_NOISE: q_reg <= cfg_data;
        REG_MEAS_NOISE: r_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched input word
  logic               op_r;
  logic [2:0]         ax_r;
  logic signed [31:0] val_r;
  logic               arr_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_data.op;
      ax_r  <= in_data.axis;
      val_r <= in_data.value;
      arr_r <= in_data.arrived;
    end
  end

  logic [31:0]       ax_w;
  logic [ADDR_W-1:0] addr;
  logic              axis_ok;

  assign ax_w    = 32'(ax_r);
  assign addr    = ax_w[ADDR_W-1:0];
  assign axis_ok = ax_w < 32'(AXES);

  // per-axis state store with valid bits
  logic [AXES-1:0]  valid;
  logic [RAM_W-1:0] rdata;
  logic [RAM_W-1:0] wdata;
  logic             we;

  // estimate and covariance working set
  logic signed [31:0] p;
  logic signed [31:0] v;
  logic signed [31:0] pp0;
  logic signed [31:0] pv0;
  logic signed [31:0] vv0;
  logic signed [31:0] lm;
  logic signed [31:0] pn;
  logic signed [31:0] vn;
  logic signed [31:0] cpp;
  logic signed [31:0] cpv;
  logic signed [31:0] cvv;

  assign we    = cmd.wb && axis_ok;
  assign wdata = {pn, vn, cpp, cpv, cvv, lm};

  cvk_ram #(
    .WIDTH (RAM_W),
    .DEPTH (AXES)
  ) u_state (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[addr] <= 1'b1;
    end
  end

  // stored values, reset values where never written or beyond the bank
  logic signed [31:0] s_p;
  logic signed [31:0] s_v;
  logic signed [31:0] s_pp;
  logic signed [31:0] s_pv;
  logic signed [31:0] s_vv;
  logic signed [31:0] s_lm;
  logic               hit;

  assign hit = axis_ok && valid[addr];
  always_comb begin
    if (hit) begin
      {s_p, s_v, s_pp, s_pv, s_vv, s_lm} = rdata;
    end else begin
      s_p  = '0;
      s_v  = '0;
      s_pp = $signed(32'(1) << FRAC_BITS);
      s_pv = '0;
      s_vv = $signed(32'(1) << FRAC_BITS);
      s_lm = '0;
    end
  end

  // intermediate terms
  logic [31:0]        t2;
  logic [31:0]        t3;
  logic [31:0]        t4;
  logic [31:0]        qpp;
  logic [31:0]        qpv;
  logic [31:0]        qvv;
  logic signed [31:0] ppr;
  logic signed [31:0] pvr;
  logic signed [31:0] vvr;
  logic signed [31:0] spp;
  logic signed [31:0] svv;
  logic signed [31:0] det;
  logic signed [31:0] n00;
  logic signed [31:0] n01;
  logic signed [31:0] n10;
  logic signed [31:0] n11;
  logic signed [31:0] k00;
  logic signed [31:0] k01;
  logic signed [31:0] k10;
  logic signed [31:0] k11;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] pvpv;
  logic signed [PROD_W-1:0] prod;

  // shared multiplier operands
  logic signed [OPND_W-1:0] ma;
  logic signed [OPND_W-1:0] mb;
  logic signed [32:0]       y0;
  logic signed [32:0]       y1;
  logic signed [OPND_W-1:0] ot;
  logic signed [OPND_W-1:0] oq;

  assign y0 = {lm[31], lm} - {p[31], p};
  assign y1 = -{v[31], v};
  assign ot = $signed({2'b00, t_reg});
  assign oq = $signed({2'b00, q_reg});

  always_comb begin
    case (cmd.step)
      ST_T2:   begin ma = ot;                       mb = ot; end
      ST_T3:   begin ma = $signed({2'b00, t2});     mb = ot; end
      ST_T4:   begin ma = $signed({2'b00, t3});     mb = ot; end
      ST_QPP:  begin ma = $signed({2'b00, t4});     mb = oq; end
      ST_QPV:  begin ma = $signed({2'b00, t3});     mb = oq; end
      ST_QVV:  begin ma = $signed({2'b00, t2});     mb = oq; end
      ST_PP1:  begin ma = ot;                       mb = OPND_W'(pv0); end
      ST_PP2:  begin ma = $signed({2'b00, t2});     mb = OPND_W'(vv0); end
      ST_PV:   begin ma = ot;                       mb = OPND_W'(vv0); end
      ST_D1:   begin ma = OPND_W'(spp);             mb = OPND_W'(svv); end
      ST_D2:   begin ma = OPND_W'(pvr);             mb = OPND_W'(pvr); end
      ST_N00:  begin ma = OPND_W'(ppr);             mb = OPND_W'(svv); end
      ST_N01A: begin ma = OPND_W'(pvr);             mb = OPND_W'(spp); end
      ST_N01B: begin ma = OPND_W'(ppr);             mb = OPND_W'(pvr); end
      ST_N10A: begin ma = OPND_W'(pvr);             mb = OPND_W'(svv); end
      ST_N10B: begin ma = OPND_W'(vvr);             mb = OPND_W'(pvr); end
      ST_N11:  begin ma = OPND_W'(vvr);             mb = OPND_W'(spp); end
      ST_X1:   begin ma = OPND_W'(k00);             mb = OPND_W'(y0); end
      ST_X2:   begin ma = OPND_W'(k01);             mb = OPND_W'(y1); end
      ST_X3:   begin ma = OPND_W'(k10);             mb = OPND_W'(y0); end
      ST_X4:   begin ma = OPND_W'(k11);             mb = OPND_W'(y1); end
      ST_C1:   begin ma = OPND_W'(k00);             mb = OPND_W'(ppr); end
      ST_C2:   begin ma = OPND_W'(k01);             mb = OPND_W'(pvr); end
      ST_C3:   begin ma = OPND_W'(k00);             mb = OPND_W'(pvr); end
      ST_C4:   begin ma = OPND_W'(k01);             mb = OPND_W'(vvr); end
      ST_C5:   begin ma = OPND_W'(k10);             mb = OPND_W'(pvr); end
      ST_C6:   begin ma = OPND_W'(k11);             mb = OPND_W'(vvr); end
      default: begin ma = '0;                       mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= ma * mb;
    end
  end

  // product scaled back, rounded toward minus infinity
  logic signed [ACC_W-1:0] prod_x;
  logic signed [ACC_W-1:0] mf;
  logic signed [31:0]      vv_w;

  assign prod_x = ACC_W'(prod);
  assign mf     = prod_x >>> FRAC_BITS;
  assign vv_w   = sat32(sx(vv0) + ux(qvv));

  // divider for the four gains
  logic signed [31:0] div_num;
  logic signed [31:0] div_q;
  logic               div_done;
  logic [1:0]         dsel;

  always_comb begin
    case (cmd.div_sel)
      GAIN_00: div_num = n00;
      GAIN_01: div_num = n01;
      GAIN_10: div_num = n10;
      GAIN_11: div_num = n11;
      default: div_num = n00;
    endcase
  end

  cvk_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel <= cmd.div_sel;
    end
    if (div_done) begin
      case (dsel)
        GAIN_00: k00 <= div_q;
        GAIN_01: k01 <= div_q;
        GAIN_10: k10 <= div_q;
        GAIN_11: k11 <= div_q;
        default: k00 <= div_q;
      endcase
    end
  end

  // state load and consume of each product
  always_ff @(posedge clk) begin
    if (cmd.load_state) begin
      p   <= s_p;
      v   <= s_v;
      pp0 <= s_pp;
      pv0 <= s_pv;
      vv0 <= s_vv;
      pn  <= (op_r == OP_SET_POS) ? val_r : s_p;
      vn  <= s_v;
      cpp <= s_pp;
      cpv <= s_pv;
      cvv <= s_vv;
      lm  <= ((op_r == OP_MEASURE) && arr_r) ? val_r : s_lm;
    end else if (cmd.acc) begin
      case (cmd.step)
        ST_T2:   t2 <= usat32(mf);
        ST_T3:   t3 <= usat32(mf);
        ST_T4:   t4 <= usat32(mf);
        ST_QPP:  qpp <= usat32(mf) >> 2;
        ST_QPV:  qpv <= usat32(mf) >> 1;
        ST_QVV:  qvv <= usat32(mf);
        ST_PP1:  acc <= sx(pp0) + ux(qpp) + (mf <<< 1);
        ST_PP2:  ppr <= sat32(acc + mf);
        ST_PV: begin
          pvr <= sat32(sx(pv0) + mf + ux(qpv));
          vvr <= vv_w;
          svv <= sat32(sx(vv_w) + (ux(r_reg) <<< 1));
          spp <= sat32(sx(ppr) + ux(r_reg));
        end
        ST_D1:   acc <= mf;
        ST_D2: begin
          det  <= sat32(acc - mf);
          pvpv <= mf;
        end
        ST_N00:  n00 <= sat32(mf - pvpv);
        ST_N01A: acc <= mf;
        ST_N01B: n01 <= sat32(acc - mf);
        ST_N10A: acc <= mf;
        ST_N10B: n10 <= sat32(acc - mf);
        ST_N11:  n11 <= sat32(mf - pvpv);
        ST_X1:   acc <= sx(p) + mf;
        ST_X2:   pn <= sat32(acc + mf);
        ST_X3:   acc <= sx(v) + mf;
        ST_X4:   vn <= sat32(acc + mf);
        ST_C1:   acc <= sx(ppr) - mf;
        ST_C2:   cpp <= sat32(acc - mf);
        ST_C3:   acc <= sx(pvr) - mf;
        ST_C4:   cpv <= sat32(acc - mf);
        ST_C5:   acc <= sx(vvr) - mf;
        ST_C6:   cvv <= sat32(acc - mf);
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data.axis_out <= ax_r;
      out_data.position <= axis_ok ? pn : '0;
      out_data.velocity <= axis_ok ? vn : '0;
    end
  end

  assign stat.div_done  = div_done;
  assign stat.skip_math = (op_r == OP_SET_POS) || !axis_ok;

endmodule
`default_nettype wire

[design/cvk_ctrl.sv]
`default_nettype none
module cvk_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      cvk_pkg::cvk_cmd_t  cmd,
  input  wire cvk_pkg::cvk_stat_t stat
);
  import cvk_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_LD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DIVW = 4'd6;
  localparam logic [3:0] S_WB   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [4:0] step;
  logic [4:0] step_next;
  logic [1:0] dsel;
  logic [1:0] dsel_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // sequencer
  always_comb begin
    state_next = state;
    step_next  = step;
    dsel_next  = dsel;
    cmd        = '0;
    cmd.step   = step;
    cmd.div_sel = dsel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: state_next = S_LD;
      S_LD: begin
        cmd.load_state = 1'b1;
        step_next      = ST_T2;
        state_next     = stat.skip_math ? S_WB : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (step == ST_N11) begin
          dsel_next  = GAIN_00;
          state_next = S_DIV;
        end else if (step == ST_C6) begin
          state_next = S_WB;
        end else begin
          step_next  = step + 5'd1;
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          if (dsel == GAIN_11) begin
            step_next  = ST_X1;
            state_next = S_MUL;
          end else begin
            dsel_next  = dsel + 2'd1;
            state_next = S_DIV;
          end
        end
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_T2;
      dsel      <= GAIN_00;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      dsel  <= dsel_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_RD)
    else $error("accepted word did not start a state read");
  a_mul_then_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.acc)
    else $error("product not consumed after multiply");
  a_fin_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> out_valid)
    else $error("result word not presented");
  a_gains_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVW && stat.div_done && dsel == GAIN_11 |=> state == S_MUL && step == ST_X1)
    else $error("correction did not follow last gain");
`endif

endmodule
`default_nettype wire
